### rtl/slot_pool_merge_evict_top_macros.svh
// Assertion macros for the slot pool block.
// Used by slot_pool_merge_evict_top; no other dependencies.
`ifndef SLOT_POOL_MERGE_EVICT_TOP_MACROS_SVH
`define SLOT_POOL_MERGE_EVICT_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Check that a condition implies another in the same cycle.
`define SPME_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spme assertion failed");
// Check that a condition implies another in the next cycle.
`define SPME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spme assertion failed");
`else
`define SPME_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SPME_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/spme_pkg.sv
// Shared types and constants of the slot pool block.
// No dependencies; used by the interfaces and the top level.
package spme_pkg;

    localparam int SLOT_DEPTH = 64;
    localparam int SLOT_W     = $clog2(SLOT_DEPTH);
    localparam int LIVE_W     = $clog2(SLOT_DEPTH + 1);

    // Request codes
    localparam logic [2:0] REQ_SPAWN  = 3'd0;
    localparam logic [2:0] REQ_SETCNT = 3'd1;
    localparam logic [2:0] REQ_REMOVE = 3'd2;
    localparam logic [2:0] REQ_EXPIRE = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    // Status codes
    localparam logic [1:0] ST_NEW     = 2'd0;
    localparam logic [1:0] ST_MERGED  = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;
    localparam logic [1:0] ST_DONE    = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_LIVE_LIMIT = 2'd0;
    localparam logic [1:0] CFG_RADIUS_SQ  = 2'd1;
    localparam logic [1:0] CFG_LIFETIME   = 2'd2;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [31:0]        now_ms;
        logic [5:0]         slot_index;
        logic [15:0]        item_id;
        logic [15:0]        count;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic               is_named;
        logic [7:0]         stack_cap;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  slot;
        logic [31:0] entity_serial;
        logic        evicted;
        logic [5:0]  evicted_slot;
        logic [6:0]  freed_count;
        logic [6:0]  live_total;
        logic [6:0]  peak_live;
        logic        changed;
    } t_rsp;

    // One stored entry, count kept in a memory of its own
    typedef struct packed {
        logic [15:0]        item;
        logic               named;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] pz;
        logic [31:0]        stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

### rtl/spme_req_if.sv
// Request channel of the slot pool block: valid, ready and a request.
// Depends on spme_pkg.
interface spme_req_if;
    logic             valid;
    logic             ready;
    spme_pkg::t_req   data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/spme_rsp_if.sv
// Response channel of the slot pool block: valid, ready and a response.
// Depends on spme_pkg.
interface spme_rsp_if;
    logic             valid;
    logic             ready;
    spme_pkg::t_rsp   data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/spme_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module spme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/slot_pool_merge_evict_top.sv
// Slot pool with merge on spawn, oldest eviction, LIFO free list.
// Depends on spme_pkg, spme_req_if, spme_rsp_if, spme_ram and the macro header.
//
//   Port     Dir  Handshake       Moves
//   i_req    in   valid/ready     one request
//   o_rsp    out  valid/ready     one response per request
//   i_cfg_*  in   write enable    live limit, merge radius, lifetime
//
// Remove frees its slot in the accepting cycle; set count reads the slot first; expire and
// clear scan every slot. Spawn: after accepting, (when it may merge) skip each slot that
// cannot merge and square each candidate's axes (the shared squaring multiplier runs once
// per axis), then check the live limit, search for the oldest entry and evict it when the
// limit is reached, and place the entry and answer; a full merge answers with no limit check.
// Synchronous active-low reset; no clearing pass. A response waiting on
// o_rsp does not stop the next request from being taken.
`include "slot_pool_merge_evict_top_macros.svh"
module slot_pool_merge_evict_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    spme_req_if.sink          i_req,
    spme_rsp_if.source        o_rsp,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data
);
    localparam int SW = spme_pkg::SLOT_W;
    localparam int LW = spme_pkg::LIVE_W;
    localparam logic [SW-1:0] LAST_SLOT = SW'(spme_pkg::SLOT_DEPTH - 1);
    localparam logic [LW-1:0] DEPTH_L   = LW'(spme_pkg::SLOT_DEPTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_M_X   = 4'd1;
    localparam logic [3:0] S_M_Y   = 4'd2;
    localparam logic [3:0] S_M_Z   = 4'd3;
    localparam logic [3:0] S_M_C   = 4'd4;
    localparam logic [3:0] S_E_CHK = 4'd5;
    localparam logic [3:0] S_E_SCN = 4'd6;
    localparam logic [3:0] S_E_FRE = 4'd7;
    localparam logic [3:0] S_T_WT  = 4'd8;
    localparam logic [3:0] S_T_TK  = 4'd9;
    localparam logic [3:0] S_SET   = 4'd10;
    localparam logic [3:0] S_X_SCN = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    // Registers
    logic [3:0]                    r_state, n_state;
    spme_pkg::t_req                r_in, n_in;
    spme_pkg::t_rsp                r_res, n_res;
    spme_pkg::t_rsp                r_out, n_out;
    logic                          r_out_valid, n_out_valid;
    logic [spme_pkg::SLOT_DEPTH-1:0] r_alive, n_alive;
    logic [SW-1:0]                 r_slot, n_slot;
    logic [15:0]                   r_rem, n_rem;
    logic [47:0]                   r_prod, n_prod;
    logic [49:0]                   r_acc, n_acc;
    logic                          r_found, n_found;
    logic [SW-1:0]                 r_old, n_old;
    logic [31:0]                   r_old_stamp, n_old_stamp;
    logic [LW-1:0]                 r_free_depth, n_free_depth;
    logic [LW-1:0]                 r_slots_used, n_slots_used;
    logic [31:0]                   r_serial, n_serial;
    logic [LW-1:0]                 r_live, n_live;
    logic [LW-1:0]                 r_peak, n_peak;
    logic [6:0]                    r_live_limit;
    logic [24:0]                   r_radius;
    logic [31:0]                   r_lifetime;

    // Memory ports and shared datapath
    logic                          dat_we;
    logic [SW-1:0]                 dat_waddr;
    spme_pkg::t_entry              dat_wdata;
    logic [spme_pkg::ENTRY_W-1:0]  dat_rdata;
    spme_pkg::t_entry              ent;
    logic                          cnt_we;
    logic [SW-1:0]                 cnt_waddr;
    logic [15:0]                   cnt_wdata;
    logic [15:0]                   cnt_rdata;
    logic                          stk_we;
    logic [SW-1:0]                 stk_waddr;
    logic [SW-1:0]                 stk_raddr;
    logic [SW-1:0]                 stk_rdata;
    logic                          do_free;
    logic [SW-1:0]                 free_idx;
    logic signed [23:0]            ax_e, ax_p;
    logic signed [24:0]            diff;
    logic [23:0]                   absd;
    logic [47:0]                   sq;
    logic [49:0]                   d2;
    logic [15:0]                   cap16;
    logic [15:0]                   add;
    logic [LW-1:0]                 take_s;
    logic                          in_fire;

    assign ent       = spme_pkg::t_entry'(dat_rdata);
    assign in_fire   = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;
    assign stk_raddr = r_free_depth[SW-1:0] - 1'b1;

    spme_ram #(.WIDTH(spme_pkg::ENTRY_W), .DEPTH(spme_pkg::SLOT_DEPTH)) u_dat (
        .i_clk(i_clk), .i_we(dat_we), .i_waddr(dat_waddr), .i_wdata(dat_wdata),
        .i_raddr(n_slot), .o_rdata(dat_rdata)
    );
    spme_ram #(.WIDTH(16), .DEPTH(spme_pkg::SLOT_DEPTH)) u_cnt (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(cnt_waddr), .i_wdata(cnt_wdata),
        .i_raddr(n_slot), .o_rdata(cnt_rdata)
    );
    spme_ram #(.WIDTH(SW), .DEPTH(spme_pkg::SLOT_DEPTH)) u_stk (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(free_idx),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    // Shared squaring unit: one axis per cycle
    always_comb begin
        case (r_state)
            S_M_X: begin
                ax_e = ent.px;
                ax_p = r_in.pos_x;
            end
            S_M_Y: begin
                ax_e = ent.py;
                ax_p = r_in.pos_y;
            end
            default: begin
                ax_e = ent.pz;
                ax_p = r_in.pos_z;
            end
        endcase
        diff = 25'(ax_e) - 25'(ax_p);
        absd = diff[24] ? 24'(-diff) : diff[23:0];
        sq   = 48'(absd) * 48'(absd);
        d2   = r_acc + 50'(r_prod);
        cap16 = 16'(r_in.stack_cap);
        add  = ((cap16 - cnt_rdata) > r_rem) ? r_rem : (cap16 - cnt_rdata);
        take_s = (r_free_depth != '0) ? LW'(stk_rdata) : r_slots_used;
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_in         = r_in;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_alive      = r_alive;
        n_slot       = r_slot;
        n_rem        = r_rem;
        n_prod       = r_prod;
        n_acc        = r_acc;
        n_found      = r_found;
        n_old        = r_old;
        n_old_stamp  = r_old_stamp;
        n_free_depth = r_free_depth;
        n_slots_used = r_slots_used;
        n_serial     = r_serial;
        n_live       = r_live;
        n_peak       = r_peak;
        dat_we       = 1'b0;
        dat_waddr    = r_slot;
        dat_wdata    = '{item: r_in.item_id, named: r_in.is_named, px: r_in.pos_x,
                         py: r_in.pos_y, pz: r_in.pos_z, stamp: r_in.now_ms};
        cnt_we       = 1'b0;
        cnt_waddr    = r_slot;
        cnt_wdata    = r_in.count;
        do_free      = 1'b0;
        free_idx     = r_slot;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_in  = i_req.data;
                    n_res = '0;
                    n_res.status = spme_pkg::ST_IGNORED;
                    n_rem = (i_req.data.count == '0) ? 16'd1 : i_req.data.count;
                    n_slot = '0;
                    n_state = S_DONE;
                    case (i_req.data.req_type)
                        spme_pkg::REQ_SPAWN: begin
                            if (i_req.data.item_id != '0) begin
                                n_state = (i_req.data.stack_cap > 8'd1 && !i_req.data.is_named)
                                          ? S_M_X : S_E_CHK;
                            end
                        end
                        spme_pkg::REQ_SETCNT: begin
                            n_slot  = i_req.data.slot_index;
                            n_state = S_SET;
                        end
                        spme_pkg::REQ_REMOVE: begin
                            if (r_alive[i_req.data.slot_index]) begin
                                do_free  = 1'b1;
                                free_idx = i_req.data.slot_index;
                                n_res.status  = spme_pkg::ST_DONE;
                                n_res.changed = 1'b1;
                            end
                        end
                        spme_pkg::REQ_EXPIRE, spme_pkg::REQ_CLEAR: begin
                            n_state = S_X_SCN;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_M_X: begin
                // Skip slots that cannot merge, else start the distance
                if (r_alive[r_slot] && ent.item == r_in.item_id && !ent.named) begin
                    n_prod  = sq;
                    n_state = S_M_Y;
                end else if (r_slot == LAST_SLOT) begin
                    n_state = S_E_CHK;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            S_M_Y: begin
                n_acc   = 50'(r_prod);
                n_prod  = sq;
                n_state = S_M_Z;
            end
            S_M_Z: begin
                n_acc   = r_acc + 50'(r_prod);
                n_prod  = sq;
                n_state = S_M_C;
            end
            S_M_C: begin
                n_state = S_M_X;
                if (d2 <= 50'(r_radius) && cnt_rdata < cap16) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_rdata + add;
                    n_rem     = r_rem - add;
                    n_res.changed = 1'b1;
                end
                if (n_rem == '0) begin
                    n_res.status = spme_pkg::ST_MERGED;
                    n_state = S_DONE;
                end else if (r_slot == LAST_SLOT) begin
                    n_state = S_E_CHK;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            S_E_CHK: begin
                n_slot  = '0;
                n_found = 1'b0;
                if (r_live >= r_live_limit || r_live >= DEPTH_L) begin
                    n_state = S_E_SCN;
                end else begin
                    n_state = S_T_WT;
                end
            end
            S_E_SCN: begin
                // Keep the smallest stamp, lowest slot on a tie
                if (r_alive[r_slot] && (!r_found || ent.stamp < r_old_stamp)) begin
                    n_found     = 1'b1;
                    n_old       = r_slot;
                    n_old_stamp = ent.stamp;
                end
                if (r_slot == LAST_SLOT) begin
                    n_state = S_E_FRE;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            S_E_FRE: begin
                if (r_found) begin
                    do_free  = 1'b1;
                    free_idx = r_old;
                    n_res.evicted      = 1'b1;
                    n_res.evicted_slot = r_old;
                end
                n_state = S_T_WT;
            end
            S_T_WT: begin
                n_state = S_T_TK;
            end
            S_T_TK: begin
                // Pop the free list, else take the next unused slot
                if (r_free_depth != '0) begin
                    n_free_depth = r_free_depth - 1'b1;
                end else if (r_slots_used < DEPTH_L) begin
                    n_slots_used = r_slots_used + 1'b1;
                end
                if (take_s < DEPTH_L) begin
                    dat_we    = 1'b1;
                    dat_waddr = take_s[SW-1:0];
                    cnt_we    = 1'b1;
                    cnt_waddr = take_s[SW-1:0];
                    cnt_wdata = r_rem;
                    n_alive[take_s[SW-1:0]] = 1'b1;
                end
                n_live = r_live + 1'b1;
                if (n_live > r_peak) begin
                    n_peak = n_live;
                end
                n_res.status        = spme_pkg::ST_NEW;
                n_res.slot          = take_s[SW-1:0];
                n_res.entity_serial = r_serial;
                n_res.changed       = 1'b1;
                n_serial = r_serial + 32'd1;
                n_state  = S_DONE;
            end
            S_SET: begin
                if (r_alive[r_slot] && cnt_rdata != r_in.count) begin
                    if (r_in.count == '0) begin
                        do_free = 1'b1;
                    end else begin
                        cnt_we = 1'b1;
                    end
                    n_res.status  = spme_pkg::ST_DONE;
                    n_res.changed = 1'b1;
                end
                n_state = S_DONE;
            end
            S_X_SCN: begin
                if (r_alive[r_slot] && (r_in.req_type == spme_pkg::REQ_CLEAR ||
                                        (r_in.now_ms - ent.stamp) > r_lifetime)) begin
                    do_free = 1'b1;
                    n_res.freed_count = r_res.freed_count + 1'b1;
                    n_res.changed     = 1'b1;
                end
                if (r_slot == LAST_SLOT) begin
                    n_res.status = spme_pkg::ST_DONE;
                    n_state = S_DONE;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out = r_res;
                    n_out.live_total = r_live;
                    n_out.peak_live  = r_peak;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Free a slot: drop alive, push on the free list
        stk_we    = do_free && (r_free_depth < DEPTH_L);
        stk_waddr = r_free_depth[SW-1:0];
        if (do_free) begin
            n_alive[free_idx] = 1'b0;
            if (r_free_depth < DEPTH_L) begin
                n_free_depth = r_free_depth + 1'b1;
            end
            if (r_live != '0) begin
                n_live = r_live - 1'b1;
            end
        end
    end

    // Hold control state under reset, payload without
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_alive      <= '0;
            r_free_depth <= '0;
            r_slots_used <= '0;
            r_serial     <= 32'd1;
            r_live       <= '0;
            r_peak       <= '0;
            r_live_limit <= 7'd64;
            r_radius     <= 25'd65536;
            r_lifetime   <= 32'd300000;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_alive      <= n_alive;
            r_free_depth <= n_free_depth;
            r_slots_used <= n_slots_used;
            r_serial     <= n_serial;
            r_live       <= n_live;
            r_peak       <= n_peak;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    spme_pkg::CFG_LIVE_LIMIT: r_live_limit <= i_cfg_data[6:0];
                    spme_pkg::CFG_RADIUS_SQ:  r_radius     <= i_cfg_data[24:0];
                    spme_pkg::CFG_LIFETIME:   r_lifetime   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in        <= n_in;
        r_res       <= n_res;
        r_out       <= n_out;
        r_slot      <= n_slot;
        r_rem       <= n_rem;
        r_prod      <= n_prod;
        r_acc       <= n_acc;
        r_found     <= n_found;
        r_old       <= n_old;
        r_old_stamp <= n_old_stamp;
    end

    // Live count tracks the alive bits and never passes the table size
    `SPME_ASSERT_IMPLY(a_live_match, i_clk, i_rst_n, 1'b1, $countones(r_alive) == r_live)
    `SPME_ASSERT_IMPLY(a_peak_bound, i_clk, i_rst_n, 1'b1, r_live <= r_peak && r_peak <= DEPTH_L)
    `SPME_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, in_fire, r_state != S_IDLE)
endmodule

### dv/tb_slot_pool_merge_evict_top.sv
// Self-checking testbench of slot_pool_merge_evict_top: directed table, then random requests.
// Depends on spme_pkg, spme_req_if, spme_rsp_if and the block; predicts every response in SV.
module tb_slot_pool_merge_evict_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = spme_pkg::SLOT_DEPTH;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [31:0] cfg_data;

    spme_req_if req_ch ();
    spme_rsp_if rsp_ch ();

    slot_pool_merge_evict_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Mirror of the slot table
    bit                 pool_alive [DEPTH];
    logic [15:0]        pool_item  [DEPTH];
    logic [15:0]        pool_count [DEPTH];
    logic signed [23:0] pool_x     [DEPTH];
    logic signed [23:0] pool_y     [DEPTH];
    logic signed [23:0] pool_z     [DEPTH];
    bit                 pool_named [DEPTH];
    logic [31:0]        pool_stamp [DEPTH];
    logic [5:0]         free_list  [DEPTH];
    int                 free_top;
    int                 slots_taken;
    int                 live_cnt;
    int                 live_max;
    logic [31:0]        serial_next;
    logic [6:0]         lim_reg;
    logic [24:0]        radius_reg;
    logic [31:0]        life_reg;

    spme_pkg::t_rsp rsp_pending [$];
    int   errors;
    bit   no_idle;
    logic [31:0] clock_ms;

    // Clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    initial begin
        #60_000_000;
        $display("tb_slot_pool_merge_evict_top NOT OK");
        $finish;
    end

    task automatic report(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void release_slot(input int s);
        pool_alive[s] = 1'b0;
        free_list[free_top] = 6'(s);
        free_top++;
        live_cnt--;
    endfunction

    // Compute the response of one request and update the mirror
    function automatic spme_pkg::t_rsp pool_step(input spme_pkg::t_req r);
        spme_pkg::t_rsp o;
        logic [15:0] n;
        longint dx, dy, dz, d2;
        int     add, s, old;
        bit     done, found;
        logic [31:0] age;
        o = '0;
        o.status = spme_pkg::ST_IGNORED;
        n = r.count;
        if (r.req_type == spme_pkg::REQ_SPAWN && r.item_id != 0) begin
            done = 0;
            if (n == 0) n = 1;
            if (r.stack_cap > 1 && !r.is_named) begin
                for (int i = 0; i < DEPTH && !done; i++) begin
                    if (!pool_alive[i] || pool_item[i] != r.item_id || pool_named[i]) continue;
                    dx = longint'(pool_x[i]) - longint'(r.pos_x);
                    dy = longint'(pool_y[i]) - longint'(r.pos_y);
                    dz = longint'(pool_z[i]) - longint'(r.pos_z);
                    d2 = dx * dx + dy * dy + dz * dz;
                    if (d2 > longint'(radius_reg)) continue;
                    if (pool_count[i] < r.stack_cap) begin
                        add = r.stack_cap - pool_count[i];
                        if (add > n) add = n;
                        pool_count[i] = pool_count[i] + 16'(add);
                        n = n - 16'(add);
                        o.changed = 1;
                        if (n == 0) done = 1;
                    end
                end
            end
            if (done) begin
                o.status = spme_pkg::ST_MERGED;
            end else begin
                // Evict the oldest entry when the pool is at its limit
                if (live_cnt >= lim_reg || live_cnt >= DEPTH) begin
                    found = 0;
                    old = 0;
                    for (int i = 0; i < DEPTH; i++) begin
                        if (!pool_alive[i]) continue;
                        if (!found || pool_stamp[i] < pool_stamp[old]) begin
                            old = i;
                            found = 1;
                        end
                    end
                    if (found) begin
                        release_slot(old);
                        o.evicted = 1;
                        o.evicted_slot = 6'(old);
                    end
                end
                if (free_top > 0) begin
                    free_top--;
                    s = free_list[free_top];
                end else begin
                    s = slots_taken;
                    slots_taken++;
                end
                live_cnt++;
                if (live_cnt > live_max) live_max = live_cnt;
                pool_alive[s] = 1;
                pool_item[s]  = r.item_id;
                pool_count[s] = n;
                pool_x[s]     = r.pos_x;
                pool_y[s]     = r.pos_y;
                pool_z[s]     = r.pos_z;
                pool_named[s] = r.is_named;
                pool_stamp[s] = r.now_ms;
                o.entity_serial = serial_next;
                serial_next++;
                o.slot = 6'(s);
                o.status = spme_pkg::ST_NEW;
                o.changed = 1;
            end
        end else if (r.req_type == spme_pkg::REQ_SETCNT) begin
            if (pool_alive[r.slot_index] && pool_count[r.slot_index] != r.count) begin
                if (r.count == 0) release_slot(r.slot_index);
                else pool_count[r.slot_index] = r.count;
                o.status = spme_pkg::ST_DONE;
                o.changed = 1;
            end
        end else if (r.req_type == spme_pkg::REQ_REMOVE) begin
            if (pool_alive[r.slot_index]) begin
                release_slot(r.slot_index);
                o.status = spme_pkg::ST_DONE;
                o.changed = 1;
            end
        end else if (r.req_type == spme_pkg::REQ_EXPIRE || r.req_type == spme_pkg::REQ_CLEAR) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (!pool_alive[i]) continue;
                age = r.now_ms - pool_stamp[i];
                if (r.req_type == spme_pkg::REQ_CLEAR || age > life_reg) begin
                    release_slot(i);
                    o.freed_count++;
                end
            end
            o.status = spme_pkg::ST_DONE;
            o.changed = o.freed_count != 0;
        end
        o.live_total = 7'(live_cnt);
        o.peak_live = 7'(live_max);
        return o;
    endfunction

    // Random response stalls
    always @(posedge i_clk) begin
        rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= 37);
    end

    task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] exp);
        if (got !== exp) report($sformatf("%s got %0h expected %0h", name, got, exp));
    endtask

    // Compare each response with the oldest expectation
    always @(posedge i_clk) begin
        spme_pkg::t_rsp e;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (rsp_pending.size() == 0) begin
                report("response with nothing expected");
            end else begin
                e = rsp_pending.pop_front();
                check_field("status", rsp_ch.data.status, e.status);
                check_field("slot", rsp_ch.data.slot, e.slot);
                check_field("entity_serial", rsp_ch.data.entity_serial, e.entity_serial);
                check_field("evicted", rsp_ch.data.evicted, e.evicted);
                check_field("evicted_slot", rsp_ch.data.evicted_slot, e.evicted_slot);
                check_field("freed_count", rsp_ch.data.freed_count, e.freed_count);
                check_field("live_total", rsp_ch.data.live_total, e.live_total);
                check_field("peak_live", rsp_ch.data.peak_live, e.peak_live);
                check_field("changed", rsp_ch.data.changed, e.changed);
            end
        end
    end

    // Offer one request, with random idle cycles ahead; valid stays high after acceptance
    task automatic send(input spme_pkg::t_req r, input bit typed, input spme_pkg::t_rsp exp);
        spme_pkg::t_rsp p;
        while (!no_idle && $urandom_range(0, 99) < 37) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        p = pool_step(r);
        rsp_pending = {rsp_pending, (typed ? exp : p)};
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (rsp_pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Write all three registers back to back
    task automatic write_cfg(input logic [6:0] lim, input logic [24:0] rad, input logic [31:0] life);
        @(posedge i_clk);
        cfg_we <= 1'b1; cfg_idx <= spme_pkg::CFG_LIVE_LIMIT; cfg_data <= 32'(lim);
        @(posedge i_clk);
        cfg_idx <= spme_pkg::CFG_RADIUS_SQ; cfg_data <= 32'(rad);
        @(posedge i_clk);
        cfg_idx <= spme_pkg::CFG_LIFETIME; cfg_data <= life;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        lim_reg = lim;
        radius_reg = rad;
        life_reg = life;
    endtask

    function automatic spme_pkg::t_req mk(input logic [2:0] rt, input logic [31:0] now,
                                          input logic [5:0] si, input logic [15:0] it,
                                          input logic [15:0] c, input int x, input int y,
                                          input int z, input bit nm, input logic [7:0] cap);
        spme_pkg::t_req r;
        r.req_type = rt; r.now_ms = now; r.slot_index = si; r.item_id = it; r.count = c;
        r.pos_x = 24'(x); r.pos_y = 24'(y); r.pos_z = 24'(z); r.is_named = nm; r.stack_cap = cap;
        return r;
    endfunction

    function automatic int pick_slot();
        int s;
        s = $urandom_range(0, DEPTH - 1);
        for (int k = 0; k < DEPTH; k++) begin
            if (pool_alive[(s + k) % DEPTH]) return (s + k) % DEPTH;
        end
        return s;
    endfunction

    // Mostly well-formed traffic around three clusters, with some noise
    function automatic spme_pkg::t_req rand_req();
        spme_pkg::t_req r;
        int   k, c, s;
        logic [159:0] raw;
        logic [7:0] caps [5] = '{8'd1, 8'd4, 8'd16, 8'd64, 8'd255};
        int   base [3] = '{0, 5000, -800000};
        k = $urandom_range(0, 99);
        clock_ms += $urandom_range(0, 2500);
        if ($urandom_range(0, 199) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
        r = mk(spme_pkg::REQ_SPAWN, clock_ms, 0, 0, 0, 0, 0, 0, 0, 8'd1);
        if (k < 55) begin
            c = base[$urandom_range(0, 2)];
            r.item_id = 16'($urandom_range(1, 3));
            r.count = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
            r.pos_x = 24'(c + $urandom_range(0, 600) - 300);
            r.pos_y = 24'(c + $urandom_range(0, 600) - 300);
            r.pos_z = 24'(-c + $urandom_range(0, 600) - 300);
            r.is_named = $urandom_range(0, 9) == 0;
            r.stack_cap = caps[$urandom_range(0, 4)];
        end else if (k < 65) begin
            s = pick_slot();
            r.req_type = spme_pkg::REQ_SETCNT;
            r.slot_index = 6'(s);
            c = $urandom_range(0, 3);
            r.count = (c == 0) ? pool_count[s] : (c == 1) ? 16'd0 : 16'($urandom_range(1, 300));
        end else if (k < 75) begin
            r.req_type = spme_pkg::REQ_REMOVE;
            r.slot_index = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'(pick_slot());
        end else if (k < 82) begin
            r.req_type = spme_pkg::REQ_EXPIRE;
        end else if (k < 84) begin
            r.req_type = spme_pkg::REQ_CLEAR;
        end else if (k < 88) begin
            r.req_type = 3'($urandom_range(5, 7));
        end else begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
            r = raw[$bits(spme_pkg::t_req)-1:0];
            if ($urandom_range(0, 1)) r.req_type = 3'($urandom_range(0, 4));
        end
        return r;
    endfunction

    initial begin
        spme_pkg::t_rsp none;
        spme_pkg::t_rsp e;
        spme_pkg::t_req dir [$];
        spme_pkg::t_rsp dexp [$];
        bit   dtyped [$];
        logic [6:0]  lims [6] = '{7'd64, 7'd1, 7'd3, 7'd0, 7'd127, 7'd8};
        logic [24:0] rads [6] = '{25'd65536, 25'd0, 25'd16777216, 25'd4000000, 25'd65536, 25'd300000};
        logic [31:0] lifes [6] = '{32'd300000, 32'd0, 32'd5000, 32'hFFFF_FFFF, 32'd20000, 32'd100000};
        none = '0;
        errors = 0;
        no_idle = 0;
        clock_ms = 0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0; cfg_idx = spme_pkg::CFG_LIVE_LIMIT; cfg_data = '0;
        req_ch.valid = 1'b0; req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        for (int i = 0; i < DEPTH; i++) pool_alive[i] = 0;
        free_top = 0; slots_taken = 0; live_cnt = 0; live_max = 0; serial_next = 1;
        lim_reg = 64; radius_reg = 65536; life_reg = 300000;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: typed expectations for the trivial rows after reset
        e = none; e.status = spme_pkg::ST_DONE;
        dir = {dir, mk(spme_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 1)};
        dexp = {dexp, e}; dtyped = {dtyped, 1'b1};
        e = none; e.status = spme_pkg::ST_IGNORED;
        dir = {dir, mk(3'd7, 0, 0, 1, 1, 0, 0, 0, 0, 1)};
        dexp = {dexp, e}; dtyped = {dtyped, 1'b1};
        dir = {dir, mk(spme_pkg::REQ_SPAWN, 0, 0, 0, 5, 0, 0, 0, 0, 64)};
        dexp = {dexp, e}; dtyped = {dtyped, 1'b1};
        e = none; e.status = spme_pkg::ST_NEW; e.entity_serial = 1; e.live_total = 1;
        e.peak_live = 1; e.changed = 1;
        dir = {dir, mk(spme_pkg::REQ_SPAWN, 100, 0, 1, 0, 0, 0, 0, 0, 64)};
        dexp = {dexp, e}; dtyped = {dtyped, 1'b1};
        dir = {dir, mk(spme_pkg::REQ_SPAWN, 200, 0, 1, 10, 100, 0, 0, 0, 64)};
        dir = {dir, mk(spme_pkg::REQ_SPAWN, 300, 0, 1, 100, 0, 0, 256, 0, 64)};
        dir = {dir, mk(spme_pkg::REQ_SPAWN, 400, 0, 1, 5, 0, 0, 0, 1, 64)};
        dir = {dir, mk(spme_pkg::REQ_SPAWN, 32'hFFFF_FFFF, 63, 16'hFFFF, 16'hFFFF,
                       8388607, 8388607, 8388607, 0, 8'd255)};
        dir = {dir, mk(spme_pkg::REQ_SPAWN, 500, 0, 16'hFFFF, 16'hFFFF,
                       -8388608, -8388608, -8388608, 0, 8'd1)};
        dir = {dir, mk(spme_pkg::REQ_SETCNT, 600, 0, 0, 64, 0, 0, 0, 0, 1)};
        dir = {dir, mk(spme_pkg::REQ_SETCNT, 600, 1, 0, 0, 0, 0, 0, 0, 1)};
        dir = {dir, mk(spme_pkg::REQ_SETCNT, 600, 63, 0, 7, 0, 0, 0, 0, 1)};
        dir = {dir, mk(spme_pkg::REQ_REMOVE, 700, 2, 0, 0, 0, 0, 0, 0, 1)};
        dir = {dir, mk(spme_pkg::REQ_REMOVE, 700, 2, 0, 0, 0, 0, 0, 0, 1)};
        dir = {dir, mk(spme_pkg::REQ_SETCNT, 700, 0, 0, 16'hFFFF, 0, 0, 0, 0, 1)};
        dir = {dir, mk(spme_pkg::REQ_SPAWN, 800, 0, 2, 3, 0, 0, 0, 0, 8'd255)};
        dir = {dir, mk(spme_pkg::REQ_EXPIRE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 1)};
        dir = {dir, mk(spme_pkg::REQ_SPAWN, 32'hFFFF_FFF0, 0, 3, 1, 0, 0, 0, 0, 4)};
        dir = {dir, mk(spme_pkg::REQ_SPAWN, 5, 0, 3, 1, 9000, 0, 0, 0, 4)};
        dir = {dir, mk(spme_pkg::REQ_EXPIRE, 100, 0, 0, 0, 0, 0, 0, 0, 1)};
        dir = {dir, mk(spme_pkg::REQ_CLEAR, 100, 0, 0, 0, 0, 0, 0, 0, 1)};
        dir = {dir, mk(spme_pkg::REQ_SPAWN, 200, 0, 4, 1, 0, 0, 0, 0, 4)};
        while (dexp.size() < dir.size()) begin
            dexp = {dexp, none};
            dtyped = {dtyped, 1'b0};
        end
        foreach (dir[i]) send(dir[i], dtyped[i], dexp[i]);

        // Random phases, each under its own register setting
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            write_cfg(lims[ph], rads[ph], lifes[ph]);
            for (int n = 0; n < 222; n++) begin
                no_idle = (ph == 2 && n >= 40 && n < 160);
                if (ph == 1 && n == 100) drain();
                send(rand_req(), 0, none);
            end
            no_idle = 0;
        end

        // Wait out the last responses
        req_ch.valid <= 1'b0;
        while (rsp_pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_slot_pool_merge_evict_top OK");
        end else begin
            $display("tb_slot_pool_merge_evict_top NOT OK");
        end
        $finish;
    end
endmodule
